### rtl/hkpt_pkg.sv
// ----------------------------------------------------------------------------
// hkpt_pkg: shared types and constants for the keyed probe table
// Sequencer states, status and kind codes, and the remainder step function.
// ----------------------------------------------------------------------------
`default_nettype none

package hkpt_pkg;

    localparam int HASH_W   = 64;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 9;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int STEPS    = HASH_W / DIGIT_W;
    localparam int STEP_CW  = $clog2(STEPS);

    // status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REM,
        ST_READ,
        ST_EVAL,
        ST_RESP
    } state_t;

    // One digit of long division: r < n on entry, result < n.
    function automatic logic [CFG_W-1:0] rem_step(
        input logic [CFG_W-1:0]   r,
        input logic [DIGIT_W-1:0] d,
        input logic [CFG_W-1:0]   n
    );
        logic [CFG_W-1:0] acc;
        logic [CFG_W:0]   t;
        acc = r;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            t = {acc, d[i]};
            if (t >= {1'b0, n}) begin
                t = t - {1'b0, n};
            end
            acc = t[CFG_W-1:0];
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### rtl/hash_keyed_probe_table.sv
// An insert on a full table goes straight to the response; otherwise the hash
// remainder (one nibble per cycle), a registered memory read and a check per
// probed slot, then the response. One item at a time; the next is taken once
// the previous result is in the output register. Probe count sets the rate.
// Reset: a clearing pass over min(SLOTS,511) slots marks every slot free;
// no item is accepted meanwhile. Configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// hash_keyed_probe_table: open-addressing table with linear probing
// Inserts value handles keyed by a 64-bit hash and looks them up again.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_keyed_probe_table #(
    parameter int SLOTS = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [hkpt_pkg::CFG_W-1:0]      cfg_wr_data,
    // input items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [hkpt_pkg::HASH_W-1:0]     s_key_hash,
    input  wire logic [hkpt_pkg::VALUE_W-1:0]    s_value,
    // result items
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [hkpt_pkg::STATUS_W-1:0]        m_status,
    output logic [hkpt_pkg::VALUE_W-1:0]         m_found_value,
    output logic [hkpt_pkg::SLOT_W-1:0]          m_slot_index
);

    // The slot count register is 9 bits, so no probe ever goes past slot 510.
    localparam int DEPTH = (SLOTS < 511) ? SLOTS : 511;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = 1 + hkpt_pkg::HASH_W + hkpt_pkg::VALUE_W;
    localparam int CW    = hkpt_pkg::CFG_W;

    hkpt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                    slots_reg;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    n_reg, n_next;
    logic [CW-1:0]                    off_reg, off_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic                             kind_reg, kind_next;
    logic [hkpt_pkg::HASH_W-1:0]      hash_reg, hash_next;
    logic [hkpt_pkg::VALUE_W-1:0]     value_reg, value_next;

    // result waiting for the output register
    logic [hkpt_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [hkpt_pkg::VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [hkpt_pkg::SLOT_W-1:0]      res_slot_reg, res_slot_next;

    // output register
    logic                             m_valid_reg, m_valid_next;
    logic [hkpt_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [hkpt_pkg::VALUE_W-1:0]     m_value_reg, m_value_next;
    logic [hkpt_pkg::SLOT_W-1:0]      m_slot_reg, m_slot_next;

    logic [CW-1:0]                    n_eff;
    logic                             accept;
    logic                             out_free;
    logic                             rem_start;
    logic                             rem_done;
    logic [CW-1:0]                    rem_val;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [DW-1:0]                    mem_wdata;
    logic [DW-1:0]                    mem_rdata;
    logic                             slot_occ;
    logic [hkpt_pkg::HASH_W-1:0]      slot_hash;
    logic [hkpt_pkg::VALUE_W-1:0]     slot_value;
    logic                             last_probe;
    logic [CW-1:0]                    idx_wide;
    logic                             clr_last;

    // zero acts as one, anything above the table depth acts as the depth
    always_comb begin
        if (slots_reg == '0) begin
            n_eff = CW'(1);
        end else if (int'(slots_reg) > DEPTH) begin
            n_eff = CW'(DEPTH);
        end else begin
            n_eff = slots_reg;
        end
    end

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign slot_occ   = mem_rdata[DW-1];
    assign slot_hash  = mem_rdata[DW-2 -: hkpt_pkg::HASH_W];
    assign slot_value = mem_rdata[hkpt_pkg::VALUE_W-1:0];
    assign last_probe = (off_reg == n_reg - 1'b1);
    assign idx_wide   = CW'(idx_reg);
    assign clr_last   = (clr_reg == AW'(DEPTH - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hkpt_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = hkpt_pkg::ST_IDLE;
                end
            end
            hkpt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_kind == hkpt_pkg::KIND_INSERT && count_reg >= n_eff) begin
                        state_next = hkpt_pkg::ST_RESP;
                    end else begin
                        state_next = hkpt_pkg::ST_REM;
                    end
                end
            end
            hkpt_pkg::ST_REM: begin
                if (rem_done) begin
                    state_next = hkpt_pkg::ST_READ;
                end
            end
            hkpt_pkg::ST_READ: begin
                state_next = hkpt_pkg::ST_EVAL;
            end
            hkpt_pkg::ST_EVAL: begin
                // keep probing past occupied slots unless a lookup matches or the last probe is done
                if (!slot_occ || last_probe ||
                    (kind_reg == hkpt_pkg::KIND_LOOKUP && slot_hash == hash_reg)) begin
                    state_next = hkpt_pkg::ST_RESP;
                end else begin
                    state_next = hkpt_pkg::ST_READ;
                end
            end
            hkpt_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = hkpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hkpt_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready         = (state_reg == hkpt_pkg::ST_IDLE);
        rem_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = {1'b1, hash_reg, value_reg};
        count_next      = count_reg;
        n_next          = n_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        hash_next       = hash_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_slot_next     = m_slot_reg;

        case (state_reg)
            hkpt_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            hkpt_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_next       = s_kind;
                    hash_next       = s_key_hash;
                    value_next      = s_value;
                    n_next          = n_eff;
                    rem_start       = 1'b1;
                    res_status_next = hkpt_pkg::STAT_FULL;
                    res_value_next  = '0;
                    res_slot_next   = '0;
                end
            end
            hkpt_pkg::ST_REM: begin
                idx_next = rem_val[AW-1:0];
                off_next = '0;
            end
            hkpt_pkg::ST_READ: begin
                // read of idx_reg is issued here, data lands for ST_EVAL
            end
            hkpt_pkg::ST_EVAL: begin
                if (kind_reg == hkpt_pkg::KIND_INSERT) begin
                    if (!slot_occ) begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = hkpt_pkg::STAT_INSERTED;
                        res_slot_next   = idx_wide[hkpt_pkg::SLOT_W-1:0];
                    end else begin
                        res_status_next = hkpt_pkg::STAT_FULL;
                    end
                end else begin
                    if (slot_occ && slot_hash == hash_reg) begin
                        res_status_next = hkpt_pkg::STAT_FOUND;
                        res_value_next  = slot_value;
                        res_slot_next   = idx_wide[hkpt_pkg::SLOT_W-1:0];
                    end else begin
                        res_status_next = hkpt_pkg::STAT_NOT_FOUND;
                    end
                end
                // advance with wrap inside the slots in use
                off_next = off_reg + 1'b1;
                if (idx_wide + 1'b1 == n_reg) begin
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hkpt_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_slot_next   = res_slot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hkpt_pkg::ST_CLEAR;
            slots_reg   <= CW'(256);
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                slots_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg          <= n_next;
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        hash_reg       <= hash_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_slot_reg     <= m_slot_next;
    end

    // start slot: hash modulo the slots in use
    hkpt_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (s_key_hash),
        .divisor   (n_eff),
        .done      (rem_done),
        .remainder (rem_val)
    );

    hkpt_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_value_reg;
    assign m_slot_index  = m_slot_reg;

endmodule

`default_nettype wire

### rtl/hkpt_rem_unit.sv
// ----------------------------------------------------------------------------
// hkpt_rem_unit: iterative hash remainder
// Reduces the 64-bit hash modulo the slot count, one nibble per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hkpt_rem_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [hkpt_pkg::HASH_W-1:0]  dividend,
    input  wire logic [hkpt_pkg::CFG_W-1:0]   divisor,
    output logic                              done,
    output logic [hkpt_pkg::CFG_W-1:0]        remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [hkpt_pkg::STEP_CW-1:0]  cnt_reg, cnt_next;
    logic [hkpt_pkg::HASH_W-1:0]   sh_reg, sh_next;
    logic [hkpt_pkg::CFG_W-1:0]    r_reg, r_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            r_next    = '0;
        end else if (busy_reg) begin
            r_next   = hkpt_pkg::rem_step(r_reg,
                           sh_reg[hkpt_pkg::HASH_W-1 -: hkpt_pkg::DIGIT_W], divisor);
            sh_next  = sh_reg << hkpt_pkg::DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hkpt_pkg::STEP_CW'(hkpt_pkg::STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg <= sh_next;
        r_reg  <= r_next;
    end

    assign done      = done_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

### rtl/hkpt_store.sv
// ----------------------------------------------------------------------------
// hkpt_store: slot memory
// One write port and one registered read port; word is {occupied, hash, value}.
// ----------------------------------------------------------------------------
`default_nettype none

module hkpt_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 97
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### test/tb_hash_keyed_probe_table.sv
// ----------------------------------------------------------------------------
// tb_hash_keyed_probe_table: self-checking bench for the keyed probe table
// Drives inserts and lookups across several slot counts, predicts every
// result with a behavioral copy of the table, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hash_keyed_probe_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 256;

    typedef struct packed {
        logic                         kind;
        logic [hkpt_pkg::HASH_W-1:0]  key_hash;
        logic [hkpt_pkg::VALUE_W-1:0] value;
    } op_item_t;

    typedef struct packed {
        logic [hkpt_pkg::STATUS_W-1:0] status;
        logic [hkpt_pkg::VALUE_W-1:0]  found_value;
        logic [hkpt_pkg::SLOT_W-1:0]   slot_index;
    } outcome_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [hkpt_pkg::CFG_W-1:0]    cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic                          s_kind      = hkpt_pkg::KIND_INSERT;
    logic [hkpt_pkg::HASH_W-1:0]   s_key_hash  = '0;
    logic [hkpt_pkg::VALUE_W-1:0]  s_value     = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [hkpt_pkg::STATUS_W-1:0] m_status;
    logic [hkpt_pkg::VALUE_W-1:0]  m_found_value;
    logic [hkpt_pkg::SLOT_W-1:0]   m_slot_index;

    hash_keyed_probe_table #(
        .SLOTS(TABLE_SLOTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key_hash    (s_key_hash),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_slot_index  (m_slot_index)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow table: tracks what the block should hold
    // ------------------------------------------------------------------------
    // register reset value
    logic [hkpt_pkg::CFG_W-1:0]   slots_cfg = hkpt_pkg::CFG_W'(TABLE_SLOTS);
    logic                         slot_used [TABLE_SLOTS];
    logic [hkpt_pkg::HASH_W-1:0]  slot_hash [TABLE_SLOTS];
    logic [hkpt_pkg::VALUE_W-1:0] slot_value[TABLE_SLOTS];
    logic [hkpt_pkg::CFG_W-1:0]   entry_count = '0;

    op_item_t   pending_items[$];     // items waiting for the driver
    outcome_t   expected_results[$];  // predicted results, oldest first
    logic [hkpt_pkg::HASH_W-1:0] key_pool[$];   // keys sent as inserts, reused by lookups and repeat inserts

    int  results_checked = 0;
    int  mismatches      = 0;
    int  hold_left       = 0;
    logic held_once      = 1'b0;
    logic steady;

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i] = 1'b0;
        end
    end

    // Both sides stop idling over this window of results.
    assign steady = (results_checked >= 500) && (results_checked < 700);

    // Apply one operation to the shadow table and return the result it gives.
    function automatic outcome_t probe_table(input op_item_t op);
        int unsigned n;
        int unsigned start;
        int unsigned idx;
        outcome_t    res;
        // register 0 behaves as 1; anything past the table size is clamped
        n = (slots_cfg == 0) ? 1 :
            ((slots_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(slots_cfg));
        start = int'(op.key_hash % 64'(n));
        res.found_value = '0;
        res.slot_index  = '0;
        if (op.kind == hkpt_pkg::KIND_INSERT) begin
            // count counts entries stranded above n too
            res.status = hkpt_pkg::STAT_FULL;
            if (entry_count < n) begin
                for (int unsigned off = 0; off < n; off++) begin
                    idx = (start + off) % n;
                    if (!slot_used[idx]) begin
                        slot_used[idx]  = 1'b1;
                        slot_hash[idx]  = op.key_hash;
                        slot_value[idx] = op.value;
                        entry_count     = entry_count + 1'b1;
                        res.status      = hkpt_pkg::STAT_INSERTED;
                        res.slot_index  = hkpt_pkg::SLOT_W'(idx);
                        break;
                    end
                end
            end
        end else begin
            res.status = hkpt_pkg::STAT_NOT_FOUND;
            for (int unsigned off = 0; off < n; off++) begin
                idx = (start + off) % n;
                if (!slot_used[idx]) begin
                    break;
                end
                if (slot_hash[idx] == op.key_hash) begin
                    res.status      = hkpt_pkg::STAT_FOUND;
                    res.found_value = slot_value[idx];
                    res.slot_index  = hkpt_pkg::SLOT_W'(idx);
                    break;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: takes items from the pending queue; valid holds until accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_items
        op_item_t nxt;
        op_item_t taken;
        logic     free;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            free = !s_valid;
            if (s_valid && s_ready) begin
                // predict at acceptance; config only changes while idle
                taken.kind     = s_kind;
                taken.key_hash = s_key_hash;
                taken.value    = s_value;
                expected_results.push_back(probe_table(taken));
                free = 1'b1;
            end
            if (free) begin
                if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 16)) begin
                    nxt = pending_items.pop_front();
                    s_valid    <= 1'b1;
                    s_kind     <= nxt.kind;
                    s_key_hash <= nxt.key_hash;
                    s_value    <= nxt.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction and drives
    // m_ready, including one long hold-off so the block backs up its input
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked <= results_checked + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: status %0d value %h slot %0d",
                             $time, m_status, m_found_value, m_slot_index);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        mismatches++;
                    end
                    if (m_found_value !== want.found_value) begin
                        $display("%0t: found_value mismatch: expected %h, actual %h",
                                 $time, want.found_value, m_found_value);
                        mismatches++;
                    end
                    if (m_slot_index !== want.slot_index) begin
                        $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                                 $time, want.slot_index, m_slot_index);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!held_once && results_checked > 200 && pending_items.size() > 8) begin
                // long back-pressure while the sender keeps offering
                held_once <= 1'b1;
                hold_left <= 300;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // Register write only with nothing in flight; the shadow follows it.
    task automatic set_slots(input logic [hkpt_pkg::CFG_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        slots_cfg    = v;
    endtask

    task automatic queue_insert(input logic [hkpt_pkg::HASH_W-1:0]  h,
                                input logic [hkpt_pkg::VALUE_W-1:0] v);
        op_item_t op;
        op.kind     = hkpt_pkg::KIND_INSERT;
        op.key_hash = h;
        op.value    = v;
        pending_items.push_back(op);
        key_pool.push_back(h);
    endtask

    task automatic queue_lookup(input logic [hkpt_pkg::HASH_W-1:0] h);
        op_item_t op;
        op.kind     = hkpt_pkg::KIND_LOOKUP;
        op.key_hash = h;
        op.value    = $urandom;     // ignored by the block
        pending_items.push_back(op);
    endtask

    // Small hashes pile onto the same start slots; the rest are full width.
    function automatic logic [hkpt_pkg::HASH_W-1:0] fresh_hash();
        if ($urandom_range(99) < 20) begin
            return hkpt_pkg::HASH_W'($urandom_range(1023));
        end
        return {$urandom, $urandom};
    endfunction

    task automatic run_random_items(input int count);
        logic [hkpt_pkg::HASH_W-1:0] h;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 45) begin
                // duplicates are legal and not detected
                if (key_pool.size() > 0 && $urandom_range(99) < 10) begin
                    h = key_pool[$urandom_range(key_pool.size() - 1)];
                end else begin
                    h = fresh_hash();
                end
                queue_insert(h, $urandom);
            end else begin
                // mostly keys that were sent, some misses
                if (key_pool.size() > 0 && $urandom_range(99) < 75) begin
                    h = key_pool[$urandom_range(key_pool.size() - 1)];
                end else begin
                    h = fresh_hash();
                end
                queue_lookup(h);
            end
        end
    endtask

    int phase_slots[12] = '{16, 1, 64, 3, 256, 128, 300, 40, 256, 8, 511, 200};

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // tiny table: collisions, duplicate key, full by count, wrap on miss
        set_slots(hkpt_pkg::CFG_W'(4));
        queue_insert('0, '0);
        queue_insert('1, '1);                         // start 3
        queue_insert(64'd4, 32'h0000_1234);           // collides with slot 0
        queue_insert(64'd4, 32'h0000_5678);           // same key again
        queue_insert(64'd8, 32'h0000_0009);           // count reached: full
        queue_lookup('0);
        queue_lookup('1);
        queue_lookup(64'd4);                          // first copy wins
        queue_lookup(64'd12);                         // one full pass, no match
        queue_lookup(64'd7);                          // wraps 3,0,1,2

        // lowered: entries above stay counted but unreachable
        set_slots(hkpt_pkg::CFG_W'(2));
        queue_insert(64'd1, 32'h0000_0001);
        queue_lookup('1);
        queue_lookup(64'd4);

        // zero behaves as one slot
        set_slots('0);
        queue_insert(64'd2, 32'h0000_0002);
        queue_lookup(64'hdead_beef_0000_0001);
        queue_lookup('0);

        // register maximum clamps to the table size
        set_slots('1);
        queue_insert('1, 32'ha5a5_a5a5);              // start 255
        queue_insert(64'h100, 32'h0000_0100);         // probes 0..4
        queue_lookup('1);
        queue_lookup(64'h103);                        // stops at a free slot
        queue_insert(64'h1ff, 32'h0000_01ff);         // wraps from 255 to slot 5
        queue_lookup(64'h1ff);

        set_slots(hkpt_pkg::CFG_W'(TABLE_SLOTS));
        queue_lookup(64'h8000_0000_0000_0004);
        queue_insert(64'h8000_0000_0000_0004, '1);

        // random phases; each setting change waits for the block to empty
        foreach (phase_slots[p]) begin
            set_slots(hkpt_pkg::CFG_W'(phase_slots[p]));
            run_random_items(100);
        end

        wait_drained();
        // let any stray result surface
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin : watchdog
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/hkpt_pkg.sv
rtl/hkpt_rem_unit.sv
rtl/hkpt_store.sv
rtl/hash_keyed_probe_table.sv
test/tb_hash_keyed_probe_table.sv
